[rtl/core/tcch_pkg.sv]
// Shared constants and types for the tile-by-class claim histogram.
`default_nettype none

package tcch_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] cfg_idx_t;

  // Operation codes carried by each input beat.
  localparam op_t OP_UPDATE = 2'd0;
  localparam op_t OP_CLEAR  = 2'd1;
  localparam op_t OP_READ   = 2'd2;
  localparam op_t OP_MODE   = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_TILES_IN_USE   = 2'd0;
  localparam cfg_idx_t REG_CLASSES_IN_USE = 2'd1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 5'd16;

  localparam int MASK_W      = 16;
  localparam int LABEL_W     = 4;
  localparam int TILE_W      = 4;
  localparam int OUT_COUNT_W = 32;
  localparam int FRAC_BITS   = 16;
  localparam int SHARE_W     = FRAC_BITS + 1;

endpackage

`default_nettype wire

[rtl/core/tcch_counter_mem.sv]
// Counter memory: one write port and one registered read port.
`default_nettype none

module tcch_counter_mem #(
  parameter int AW    = 8,
  parameter int DW    = 32,
  parameter int DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tcch_share_div.sv]
// Restoring divider that forms floor(best * 2^16 / total), one quotient bit a cycle.
`default_nettype none

module tcch_share_div #(
  parameter int SW = 37
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [SW-1:0]               best,
  input  wire logic [SW-1:0]               total,
  output logic                             done,
  output logic [tcch_pkg::SHARE_W-1:0]     share
);

  logic                              running;
  logic [4:0]                        cnt;
  logic [SW:0]                       rem;
  logic [SW-1:0]                     den;
  logic [tcch_pkg::FRAC_BITS-1:0]    q;
  logic                              full;
  logic                              zero;
  logic [SW:0]                       shifted;
  logic                              fits;

  assign shifted = {rem[SW-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= {1'b0, best};
        den     <= total;
        q       <= '0;
        full    <= (best == total);
        zero    <= (total == '0);
      end else if (running) begin
        if (fits) begin
          rem <= shifted - {1'b0, den};
        end else begin
          rem <= shifted;
        end
        q   <= {q[tcch_pkg::FRAC_BITS-2:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(tcch_pkg::FRAC_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // A best count equal to the total is a share of exactly one.
  always_comb begin
    if (zero) begin
      share = '0;
    end else if (full) begin
      share = {1'b1, {tcch_pkg::FRAC_BITS{1'b0}}};
    end else begin
      share = {1'b0, q};
    end
  end

endmodule

`default_nettype wire

[rtl/core/tile_class_claim_histogram.sv]
// Top level of the tile-by-class claim histogram with its operation sequencer.
//
// The block keeps one saturating claim counter for every (tile, class) pair in a
// single-port-write, registered-read memory and works on one command beat at a
// time: a beat is taken when start is high and busy is low, and its one result
// appears on the result ports for exactly one cycle with done high; the receiver
// cannot stall it. An update walks the tiles in use, at most sixteen, one per
// cycle through a read-modify-write pipeline. A read addresses the memory while
// idle and answers from the READ state. A mode query walks the tiles in use one
// per cycle, summing and comparing, then runs the bit-serial share divider for
// its 16 quotient steps and hands the share over; it skips the divider when the
// class holds no claims. Commands that name an index out of range answer in the
// next cycle with status high. A clear sweeps the memory one counter per cycle,
// all TILE_COUNT * 2^ceil(log2(CLASS_COUNT)) counters (256 at the default sizes),
// and answers in the cycle after the sweep ends. The same sweep runs after reset
// while busy stays high and no command is taken. Configuration writes are always
// ready and should only be issued while idle.
`default_nettype none

module tile_class_claim_histogram #(
  parameter int TILE_COUNT  = 16,
  parameter int CLASS_COUNT = 16,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Command channel.
  input  wire logic                                start,
  output logic                                     busy,
  input  wire tcch_pkg::op_t                       operation,
  input  wire logic [tcch_pkg::MASK_W-1:0]         route_mask,
  input  wire logic [tcch_pkg::LABEL_W-1:0]        class_label,
  input  wire logic [tcch_pkg::TILE_W-1:0]         tile_index,
  // Result channel.
  output logic                                     done,
  output logic                                     status,
  output logic [tcch_pkg::OUT_COUNT_W-1:0]         claim_count,
  output logic                                     mode_found,
  output logic [tcch_pkg::TILE_W-1:0]              mode_tile,
  output logic [tcch_pkg::SHARE_W-1:0]             mode_share,
  // Configuration write channel.
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire tcch_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [tcch_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Memory address is {tile, class}; the class field is rounded up to a power of two.
  localparam int TB    = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int CB    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int AW    = TB + CB;
  localparam int DEPTH = TILE_COUNT * (2 ** CB);
  // The tile walk counter must reach any tiles_in_use value and any built tile.
  localparam int TW    = (TB > tcch_pkg::CFG_DATA_W) ? TB : tcch_pkg::CFG_DATA_W;
  localparam int LW    = (CB > tcch_pkg::LABEL_W) ? CB : tcch_pkg::LABEL_W;
  // A class total over up to 31 tiles needs five more bits than one counter.
  localparam int SW    = COUNT_BITS + 5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;

  logic [2:0]                           state;
  logic [tcch_pkg::CFG_DATA_W-1:0]      tiles_in_use;
  logic [tcch_pkg::CFG_DATA_W-1:0]      classes_in_use;

  // Sequencer registers.
  logic [AW-1:0]                        caddr;
  logic                                 clr_report;
  logic [tcch_pkg::MASK_W-1:0]          mask_q;
  logic [CB-1:0]                        label_q;
  logic [TW-1:0]                        tcnt;
  logic [TW-1:0]                        limit;
  logic                                 pend;
  logic                                 pend_hit;
  logic [AW-1:0]                        pend_addr;
  logic [TW-1:0]                        pend_tile;
  logic [COUNT_BITS-1:0]                best;
  logic [TW-1:0]                        best_t;
  logic [SW-1:0]                        sum;

  // Decoded command fields.
  logic [tcch_pkg::CFG_DATA_W-1:0]      nt;
  logic [tcch_pkg::CFG_DATA_W-1:0]      nc;
  logic [tcch_pkg::CFG_DATA_W-1:0]      upd_tiles;
  logic                                 label_ok;
  logic                                 tile_ok;
  logic [LW-1:0]                        label_ext;
  logic [TW-1:0]                        tile_ext;
  logic                                 accept;
  logic                                 issue;

  // Memory and divider connections.
  logic                                 mem_we;
  logic [AW-1:0]                        mem_waddr;
  logic [COUNT_BITS-1:0]                mem_wdata;
  logic [AW-1:0]                        mem_raddr;
  logic [COUNT_BITS-1:0]                mem_rdata;
  logic                                 div_start;
  logic                                 div_done;
  logic [tcch_pkg::SHARE_W-1:0]         div_share;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Register values above the built size fall back to the built size.
  assign nt = (32'(tiles_in_use) < TILE_COUNT) ? tiles_in_use
                                                : tcch_pkg::CFG_DATA_W'(TILE_COUNT);
  assign nc = (32'(classes_in_use) < CLASS_COUNT) ? classes_in_use
                                                   : tcch_pkg::CFG_DATA_W'(CLASS_COUNT);
  // The route mask only reaches the first sixteen tiles.
  assign upd_tiles = (nt > tcch_pkg::CFG_DATA_W'(tcch_pkg::MASK_W))
                   ? tcch_pkg::CFG_DATA_W'(tcch_pkg::MASK_W) : nt;

  assign label_ok  = {1'b0, class_label} < nc;
  assign tile_ok   = {1'b0, tile_index} < nt;
  assign label_ext = LW'(class_label);
  assign tile_ext  = TW'(tile_index);

  // One tile is read per cycle while the walk counter is below its limit.
  assign issue = ((state == S_UPDATE) || (state == S_SCAN)) && (tcnt < limit);

  // While idle the read port looks at the incoming command so the counter is ready in the READ state.
  assign mem_raddr = (state == S_IDLE) ? {tile_ext[TB-1:0], label_ext[CB-1:0]}
                                       : {tcnt[TB-1:0], label_q};

  // Outside a clear the write follows the registered read; a counter at its ceiling is left alone.
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = caddr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_UPDATE) && pend && pend_hit && (mem_rdata != CNT_MAX);
      mem_waddr = pend_addr;
      mem_wdata = mem_rdata + COUNT_BITS'(1);
    end
  end

  assign div_start = (state == S_SCAN) && !issue && !pend && (best != '0);

  tcch_counter_mem #(
    .AW    (AW),
    .DW    (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcch_share_div #(
    .SW (SW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .best  (SW'(best)),
    .total (sum),
    .done  (div_done),
    .share (div_share)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_in_use   <= tcch_pkg::CFG_RESET_VALUE;
      classes_in_use <= tcch_pkg::CFG_RESET_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcch_pkg::REG_TILES_IN_USE:   tiles_in_use   <= cfg_data;
        tcch_pkg::REG_CLASSES_IN_USE: classes_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      caddr      <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      pend       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          caddr <= caddr + AW'(1);
          if (caddr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
            caddr <= '0;
            if (clr_report) begin
              done        <= 1'b1;
              status      <= 1'b0;
              claim_count <= '0;
              mode_found  <= 1'b0;
              mode_tile   <= '0;
              mode_share  <= '0;
            end
          end
        end

        S_IDLE: begin
          if (accept) begin
            mask_q  <= route_mask;
            label_q <= label_ext[CB-1:0];
            tcnt    <= '0;
            pend    <= 1'b0;
            best    <= '0;
            best_t  <= '0;
            sum     <= '0;
            // Every field not set by the operation reads as zero.
            status      <= 1'b0;
            claim_count <= '0;
            mode_found  <= 1'b0;
            mode_tile   <= '0;
            mode_share  <= '0;
            case (operation)
              tcch_pkg::OP_UPDATE: begin
                limit <= TW'(upd_tiles);
                if (label_ok) begin
                  state <= S_UPDATE;
                end else begin
                  status <= 1'b1;
                  done   <= 1'b1;
                end
              end
              tcch_pkg::OP_CLEAR: begin
                state      <= S_CLEAR;
                caddr      <= '0;
                clr_report <= 1'b1;
              end
              tcch_pkg::OP_READ: begin
                if (label_ok && tile_ok) begin
                  state <= S_READ;
                end else begin
                  status <= 1'b1;
                  done   <= 1'b1;
                end
              end
              default: begin
                limit <= TW'(nt);
                if (label_ok) begin
                  state <= S_SCAN;
                end else begin
                  status <= 1'b1;
                  done   <= 1'b1;
                end
              end
            endcase
          end
        end

        S_UPDATE: begin
          pend <= issue;
          if (issue) begin
            pend_addr <= mem_raddr;
            pend_hit  <= mask_q[tcnt[3:0]];
            tcnt      <= tcnt + TW'(1);
          end else if (!pend) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end

        S_READ: begin
          claim_count <= tcch_pkg::OUT_COUNT_W'(mem_rdata);
          state       <= S_IDLE;
          done        <= 1'b1;
        end

        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            pend_tile <= tcnt;
            tcnt      <= tcnt + TW'(1);
          end
          // Strictly greater keeps the lowest tile on ties.
          if (pend) begin
            sum <= sum + SW'(mem_rdata);
            if (mem_rdata > best) begin
              best   <= mem_rdata;
              best_t <= pend_tile;
            end
          end
          if (!issue && !pend) begin
            if (best == '0) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            mode_found  <= 1'b1;
            mode_tile   <= best_t[tcch_pkg::TILE_W-1:0];
            claim_count <= tcch_pkg::OUT_COUNT_W'(best);
            mode_share  <= div_share;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcch_checker.sv]
// Port-level checks for the claim histogram and the bind that attaches them.
`default_nettype none

module tcch_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic                                done,
  input  wire logic                                status,
  input  wire logic [tcch_pkg::OUT_COUNT_W-1:0]    claim_count,
  input  wire logic                                mode_found,
  input  wire logic [tcch_pkg::TILE_W-1:0]         mode_tile,
  input  wire logic [tcch_pkg::SHARE_W-1:0]        mode_share
);

  // A taken command either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("command taken but block neither busy nor answering");

  // A result only follows work in progress or a command taken the cycle before.
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result beat without a command");

  // An out-of-range answer carries no count, no tile and no share.
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    done && status |-> !mode_found && claim_count == '0 && mode_tile == '0
                       && mode_share == '0)
    else $error("out-of-range result carries data");

  // Without a mode hit the tile and share stay zero.
  a_no_mode_fields: assert property (@(posedge clk) disable iff (rst)
    done && !mode_found |-> mode_tile == '0 && mode_share == '0)
    else $error("mode fields set without a mode hit");

  // A mode hit always has a nonzero share and a good status.
  a_mode_share: assert property (@(posedge clk) disable iff (rst)
    done && mode_found |-> mode_share != '0 && !status)
    else $error("mode hit with zero share or bad status");

endmodule

bind tile_class_claim_histogram tcch_checker u_tcch_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .claim_count (claim_count),
  .mode_found  (mode_found),
  .mode_tile   (mode_tile),
  .mode_share  (mode_share)
);

`default_nettype wire
